### src/hhlp_pkg.sv
`timescale 1ns / 1ps

package hhlp_pkg;

  localparam int MAX_LINE  = 4096;
  localparam int LINE_W    = $clog2(MAX_LINE);
  localparam int FIELD_W   = 12;
  localparam int LEN_W     = 31;
  localparam int NAME_MAX  = 14;
  localparam int NCAND     = 4;
  localparam int WIDE_W    = (LINE_W + 1 > FIELD_W + 1) ? LINE_W + 1 : FIELD_W + 1;

  localparam logic [FIELD_W-1:0] FIELD_MAX = {FIELD_W{1'b1}};
  localparam logic [LEN_W-1:0]   LEN_MAX   = {LEN_W{1'b1}};

  localparam logic [31:0]  TXT_HOST   = "Host";
  localparam logic [79:0]  TXT_AGENT  = "User-Agent";
  localparam logic [95:0]  TXT_TYPE   = "Content-Type";
  localparam logic [111:0] TXT_LENGTH = "Content-Length";

  typedef enum logic [3:0] {
    BC_NUL,
    BC_CR,
    BC_LF,
    BC_COLON,
    BC_BLANK,
    BC_VTFF,
    BC_PLUS,
    BC_MINUS,
    BC_DIGIT,
    BC_OTHER
  } byte_class_t;

  typedef enum logic [2:0] {
    PH_LINE_START,
    PH_START_CR,
    PH_NAME,
    PH_VALUE,
    PH_VALUE_CR,
    PH_IDLE
  } phase_t;

  typedef enum logic [1:0] {
    TRIM_LEAD,
    TRIM_IN_NAME,
    TRIM_TRAIL
  } trim_t;

  typedef enum logic [1:0] {
    NUM_EXPECT,
    NUM_DIGITS,
    NUM_DONE
  } num_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_END,
    ST_BAD
  } status_t;

  typedef enum logic [2:0] {
    KIND_NONE,
    KIND_HOST,
    KIND_AGENT,
    KIND_TYPE,
    KIND_LENGTH
  } kind_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       new_request;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [2:0]         header_kind;
    logic [LEN_W-1:0]   content_length;
    logic [FIELD_W-1:0] value_offset;
    logic [FIELD_W-1:0] value_length;
    logic [3:0]         seen_mask;
  } out_item_t;

  // One classified beat as it travels from the front to the back.
  typedef struct packed {
    logic                               new_request;
    byte_class_t                        cls;
    logic [3:0]                         digit;
    logic [NCAND-1:0][NAME_MAX-1:0]     hit;
  } cls_item_t;

  function automatic int cand_len(input int k);
    int r;
    r = 0;
    unique case (k)
      0: r = 4;
      1: r = 10;
      2: r = 12;
      3: r = 14;
      default: r = 0;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] cand_char(input int k, input int i);
    logic [7:0] c;
    c = 8'h00;
    if (i < cand_len(k)) begin
      unique case (k)
        0: c = TXT_HOST[8*(3-i) +: 8];
        1: c = TXT_AGENT[8*(9-i) +: 8];
        2: c = TXT_TYPE[8*(11-i) +: 8];
        3: c = TXT_LENGTH[8*(13-i) +: 8];
        default: c = 8'h00;
      endcase
    end
    return c;
  endfunction

  function automatic logic [FIELD_W-1:0] sat_field(input logic [LINE_W:0] v);
    logic [WIDE_W-1:0] e;
    e = WIDE_W'(v);
    return (e > WIDE_W'(FIELD_MAX)) ? FIELD_MAX : e[FIELD_W-1:0];
  endfunction

endpackage

### src/hhlp_front.sv
`timescale 1ns / 1ps

module hhlp_front (
  input  hhlp_pkg::in_item_t  in_data,
  output hhlp_pkg::cls_item_t cls_data
);
  import hhlp_pkg::*;

  logic [7:0] b;

  assign b = in_data.data_byte;

  always_comb begin
    cls_data = '0;
    cls_data.new_request = in_data.new_request;
    cls_data.digit = b[3:0];
    priority if (b == 8'h00) begin
      cls_data.cls = BC_NUL;
    end else if (b == 8'h0D) begin
      cls_data.cls = BC_CR;
    end else if (b == 8'h0A) begin
      cls_data.cls = BC_LF;
    end else if (b == ":") begin
      cls_data.cls = BC_COLON;
    end else if (b == 8'h20 || b == 8'h09) begin
      cls_data.cls = BC_BLANK;
    end else if (b == 8'h0B || b == 8'h0C) begin
      cls_data.cls = BC_VTFF;
    end else if (b == "+") begin
      cls_data.cls = BC_PLUS;
    end else if (b == "-") begin
      cls_data.cls = BC_MINUS;
    end else if (b >= "0" && b <= "9") begin
      cls_data.cls = BC_DIGIT;
    end else begin
      cls_data.cls = BC_OTHER;
    end
    // Match the byte against every character position of every known name,
    // so the back end only has to pick the column of its current index.
    for (int k = 0; k < NCAND; k++) begin
      for (int i = 0; i < NAME_MAX; i++) begin
        cls_data.hit[k][i] = (i < cand_len(k)) && (b == cand_char(k, i));
      end
    end
  end

endmodule

### src/hhlp_queue.sv
`timescale 1ns / 1ps

module hhlp_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  hhlp_pkg::cls_item_t push_data,
  output logic                full,
  input  logic                pop,
  output logic                pop_valid,
  output hhlp_pkg::cls_item_t pop_data
);
  import hhlp_pkg::*;

  cls_item_t  slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_push, do_pop;

  assign full      = (count_r == 2'd2);
  assign pop_valid = (count_r != 2'd0);
  assign pop_data  = slot_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != 2'd3)
    else $error("queue count out of range");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == 2'd1) |-> (wr_ptr_r != rd_ptr_r))
    else $error("queue pointers disagree with count");

endmodule

### src/hhlp_back.sv
`timescale 1ns / 1ps

module hhlp_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  hhlp_pkg::cls_item_t q_data,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output hhlp_pkg::out_item_t out_data
);
  import hhlp_pkg::*;

  phase_t              phase_r, phase_nxt, cur_phase;
  logic [LINE_W-1:0]   lp_r, lp_nxt, cur_lp;
  logic [3:0]          idx_r, idx_nxt, cur_idx;
  logic [NCAND-1:0]    cand_r, cand_nxt, cur_cand;
  trim_t               trim_r, trim_nxt, cur_trim;
  logic [LINE_W-1:0]   first_r, first_nxt, cur_first;
  logic [LINE_W-1:0]   last_r, last_nxt, cur_last;
  logic                nonblank_r, nonblank_nxt, cur_nonblank;
  num_t                num_r, num_nxt, cur_num;
  logic                neg_r, neg_nxt, cur_neg;
  logic [LEN_W-1:0]    acc_r, acc_nxt, cur_acc;
  logic [LEN_W-1:0]    stored_r, stored_nxt, cur_stored;
  logic [3:0]          seen_r, seen_nxt, cur_seen;

  logic                out_valid_r;
  out_item_t           out_data_r;
  logic                go;
  logic                emit_c;
  status_t             res_status;
  kind_t               res_kind;
  logic [FIELD_W-1:0]  res_off, res_len;
  logic                blank, fail;
  logic [NCAND-1:0]    hit_now;
  kind_t               kind;
  logic [3:0]          kind_bit;
  logic [LEN_W+3:0]    acc_ext, acc_mul;
  logic [LINE_W:0]     len_w;

  assign go        = q_valid && (!out_valid_r || !out_stall);
  assign q_pop     = go;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign blank     = (q_data.cls == BC_BLANK);

  always_comb begin
    // A new request starts from a fresh line and an empty record.
    if (q_data.new_request) begin
      cur_phase = PH_LINE_START;  cur_lp = '0;     cur_idx = '0;
      cur_cand = '1;              cur_trim = TRIM_LEAD;
      cur_first = '0;             cur_last = '0;   cur_nonblank = 1'b0;
      cur_num = NUM_EXPECT;       cur_neg = 1'b0;  cur_acc = '0;
      cur_stored = '0;            cur_seen = '0;
    end else begin
      cur_phase = phase_r;        cur_lp = lp_r;   cur_idx = idx_r;
      cur_cand = cand_r;          cur_trim = trim_r;
      cur_first = first_r;        cur_last = last_r; cur_nonblank = nonblank_r;
      cur_num = num_r;            cur_neg = neg_r; cur_acc = acc_r;
      cur_stored = stored_r;      cur_seen = seen_r;
    end

    phase_nxt = cur_phase;  idx_nxt = cur_idx;    cand_nxt = cur_cand;
    trim_nxt = cur_trim;    first_nxt = cur_first; last_nxt = cur_last;
    nonblank_nxt = cur_nonblank;  num_nxt = cur_num;  neg_nxt = cur_neg;
    acc_nxt = cur_acc;      stored_nxt = cur_stored; seen_nxt = cur_seen;
    lp_nxt = (cur_lp < LINE_W'(MAX_LINE - 1)) ? cur_lp + 1'b1 : cur_lp;

    emit_c = 1'b0;  fail = 1'b0;
    res_status = ST_OK;  res_kind = KIND_NONE;  res_off = '0;  res_len = '0;

    for (int k = 0; k < NCAND; k++) begin
      hit_now[k] = (cur_idx < 4'(NAME_MAX)) && q_data.hit[k][cur_idx];
    end
    kind = KIND_NONE;
    for (int k = 0; k < NCAND; k++) begin
      if (cur_cand[k] && cur_idx == 4'(cand_len(k))) begin
        kind = kind_t'(k + 1);
      end
    end
    kind_bit = 4'b0001 << (3'(kind) - 3'd1);

    acc_ext = (LEN_W+4)'(cur_acc);
    acc_mul = (acc_ext << 3) + (acc_ext << 1) + (LEN_W+4)'(q_data.digit);
    len_w   = (LINE_W+1)'(cur_last) - (LINE_W+1)'(cur_first) + 1'b1;

    unique case (cur_phase)
      PH_LINE_START, PH_NAME: begin
        if (cur_phase == PH_LINE_START && q_data.cls == BC_CR) begin
          phase_nxt = PH_START_CR;
        end else if (q_data.cls == BC_COLON) begin
          phase_nxt = PH_VALUE;
        end else if (q_data.cls == BC_NUL || q_data.cls == BC_CR ||
                     q_data.cls == BC_LF) begin
          fail = 1'b1;
        end else begin
          phase_nxt = PH_NAME;
          if (blank) begin
            if (cur_trim == TRIM_IN_NAME) begin
              trim_nxt = TRIM_TRAIL;
            end
          end else begin
            // A character after inner blanks can never match a known name.
            cand_nxt = (cur_trim == TRIM_TRAIL) ? '0 : (cur_cand & hit_now);
            trim_nxt = TRIM_IN_NAME;
            if (cur_idx != 4'hF) begin
              idx_nxt = cur_idx + 1'b1;
            end
          end
        end
      end
      PH_START_CR: begin
        if (q_data.cls == BC_LF) begin
          phase_nxt  = PH_IDLE;
          emit_c     = 1'b1;
          res_status = ST_END;
        end else begin
          fail = 1'b1;
        end
      end
      PH_VALUE: begin
        if (q_data.cls == BC_CR) begin
          phase_nxt = PH_VALUE_CR;
        end else if (q_data.cls == BC_NUL || q_data.cls == BC_LF) begin
          fail = 1'b1;
        end else begin
          if (!blank) begin
            if (!cur_nonblank) begin
              first_nxt    = cur_lp;
              nonblank_nxt = 1'b1;
            end
            last_nxt = cur_lp;
          end
          if (cur_num == NUM_EXPECT &&
              (q_data.cls == BC_PLUS || q_data.cls == BC_MINUS)) begin
            neg_nxt = (q_data.cls == BC_MINUS);
            num_nxt = NUM_DIGITS;
          end else if (cur_num == NUM_EXPECT && (blank || q_data.cls == BC_VTFF)) begin
            num_nxt = NUM_EXPECT;
          end else if (cur_num != NUM_DONE) begin
            if (q_data.cls == BC_DIGIT) begin
              num_nxt = NUM_DIGITS;
              acc_nxt = (acc_mul > (LEN_W+4)'(LEN_MAX)) ? LEN_MAX : acc_mul[LEN_W-1:0];
            end else begin
              num_nxt = NUM_DONE;
            end
          end
        end
      end
      PH_VALUE_CR: begin
        if (q_data.cls != BC_LF || !cur_nonblank) begin
          fail = 1'b1;
        end else if (kind != KIND_NONE && (cur_seen & kind_bit) != 4'd0) begin
          fail = 1'b1;
        end else begin
          seen_nxt = (kind != KIND_NONE) ? (cur_seen | kind_bit) : cur_seen;
          if (kind == KIND_LENGTH && cur_neg && cur_acc != '0) begin
            // The header still counts as seen; the stored length stays.
            fail = 1'b1;
          end else begin
            if (kind == KIND_LENGTH) begin
              stored_nxt = cur_acc;
            end
            emit_c     = 1'b1;
            res_status = ST_OK;
            res_kind   = kind;
            res_off    = sat_field((LINE_W+1)'(cur_first));
            res_len    = sat_field(len_w);
            phase_nxt  = PH_LINE_START;
            lp_nxt     = '0;  idx_nxt = '0;  cand_nxt = '1;  trim_nxt = TRIM_LEAD;
            first_nxt  = '0;  last_nxt = '0; nonblank_nxt = 1'b0;
            num_nxt    = NUM_EXPECT;  neg_nxt = 1'b0;  acc_nxt = '0;
          end
        end
      end
      default: begin
      end
    endcase

    if (fail) begin
      phase_nxt  = PH_IDLE;
      emit_c     = 1'b1;
      res_status = ST_BAD;
      res_kind   = KIND_NONE;
      res_off    = '0;
      res_len    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_LINE_START;  lp_r <= '0;  idx_r <= '0;  cand_r <= '1;
      trim_r <= TRIM_LEAD;  first_r <= '0;  last_r <= '0;  nonblank_r <= 1'b0;
      num_r <= NUM_EXPECT;  neg_r <= 1'b0;  acc_r <= '0;  stored_r <= '0;
      seen_r <= '0;  out_valid_r <= 1'b0;
    end else begin
      if (go) begin
        phase_r <= phase_nxt;  lp_r <= lp_nxt;  idx_r <= idx_nxt;
        cand_r <= cand_nxt;  trim_r <= trim_nxt;  first_r <= first_nxt;
        last_r <= last_nxt;  nonblank_r <= nonblank_nxt;  num_r <= num_nxt;
        neg_r <= neg_nxt;  acc_r <= acc_nxt;  stored_r <= stored_nxt;
        seen_r <= seen_nxt;
        out_valid_r <= emit_c;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go && emit_c) begin
      out_data_r.status         <= 2'(res_status);
      out_data_r.header_kind    <= 3'(res_kind);
      out_data_r.content_length <= stored_nxt;
      out_data_r.value_offset   <= res_off;
      out_data_r.value_length   <= res_len;
      out_data_r.seen_mask      <= seen_nxt;
    end
  end

  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (go && phase_r == PH_IDLE && !q_data.new_request) |-> !emit_c)
    else $error("result produced while ignoring bytes");

  a_ok_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (go && emit_c && res_status == ST_OK) |-> (phase_nxt == PH_LINE_START))
    else $error("accepted line did not restart the parser");

  a_seen_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (go && !q_data.new_request) |-> ((seen_nxt & seen_r) == seen_r))
    else $error("seen flag dropped without a new request");

  a_value_order: assert property (@(posedge clk) disable iff (!rst_n)
    nonblank_r |-> (last_r >= first_r))
    else $error("trimmed value ends before it starts");

endmodule

### src/http_header_line_parser_top.sv
`timescale 1ns / 1ps

// Streaming HTTP header line parser: one header byte per input beat, and one
// result beat for each line that is accepted, for the end of the headers, or
// for the first format error, after which bytes are dropped until a beat with
// new_request set. The block takes one byte every clock cycle while in_stall
// is low; the front classifies the byte and matches it against the known
// header names, a two-entry queue holds classified bytes, and the back
// updates the parse state for each byte that it pops. A result is registered
// after its last byte passes the queue; in_stall rises only when the queue
// is full because the output register is held by out_stall.
module http_header_line_parser_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  hhlp_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output hhlp_pkg::out_item_t out_data
);
  import hhlp_pkg::*;

  cls_item_t cls_in, cls_out;
  logic      q_full, q_pop, q_valid;

  hhlp_front u_front (
    .in_data  (in_data),
    .cls_data (cls_in)
  );

  hhlp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_valid),
    .push_data (cls_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_data  (cls_out)
  );

  hhlp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (cls_out),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign in_stall = q_full;

endmodule

### bench/http_header_line_parser_top_tb.sv
`timescale 1ns / 1ps

module http_header_line_parser_top_tb;
  import hhlp_pkg::*;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_COLON = 8'h3A;

  localparam int RANDOM_BYTES = 620;
  localparam int QUIET_FROM   = 650;
  localparam int QUIET_TO     = 1000;
  localparam int HOLD_AT_A    = 400;
  localparam int HOLD_AT_B    = 1150;
  localparam int HOLD_LEN     = 150;
  localparam int DRAIN_CYCLES = 20;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  http_header_line_parser_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  in_item_t  byte_q[$];
  out_item_t line_result_q[$];
  int        mismatch_count = 0;
  int        cyc = 0;
  int        hold_left = 0;
  bit        open_pending = 1'b0;

  // Header record kept alongside the block.
  phase_t            ph;
  logic [LINE_W-1:0] line_pos;
  int                name_idx;
  logic [3:0]        cands;
  trim_t             name_trim;
  int                val_first;
  int                val_last;
  bit                val_nonblank;
  num_t              num_ph;
  bit                num_neg;
  logic [LEN_W-1:0]  len_acc;
  logic [LEN_W-1:0]  len_stored;
  logic [3:0]        seen;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic string hdr_name(input int k);
    case (k)
      0: return "Host";
      1: return "User-Agent";
      2: return "Content-Type";
      default: return "Content-Length";
    endcase
  endfunction

  function automatic kind_t hdr_kind(input int k);
    case (k)
      0: return KIND_HOST;
      1: return KIND_AGENT;
      2: return KIND_TYPE;
      default: return KIND_LENGTH;
    endcase
  endfunction

  function automatic bit is_blank(input logic [7:0] b);
    return b == CH_SP || b == CH_TAB;
  endfunction

  function automatic logic [FIELD_W-1:0] clip_field(input int v);
    return (v > int'(FIELD_MAX)) ? FIELD_MAX : v[FIELD_W-1:0];
  endfunction

  function automatic bit take_break();
    if (cyc >= QUIET_FROM && cyc < QUIET_TO) return 1'b0;
    return $urandom_range(99) < 12;
  endfunction

  task automatic clear_line();
    ph = PH_LINE_START;
    line_pos = '0;
    name_idx = 0;
    cands = 4'hF;
    name_trim = TRIM_LEAD;
    val_first = 0;
    val_last = 0;
    val_nonblank = 1'b0;
    num_ph = NUM_EXPECT;
    num_neg = 1'b0;
    len_acc = '0;
  endtask

  task automatic reset_record();
    clear_line();
    len_stored = '0;
    seen = '0;
  endtask

  task automatic push_result(input status_t st, input kind_t kd, input int off, input int len);
    out_item_t r;
    r.status = st;
    r.header_kind = kd;
    r.content_length = len_stored;
    r.value_offset = clip_field(off);
    r.value_length = clip_field(len);
    r.seen_mask = seen;
    line_result_q.push_back(r);
  endtask

  task automatic reject_line();
    ph = PH_IDLE;
    push_result(ST_BAD, KIND_NONE, 0, 0);
  endtask

  task automatic name_step(input logic [7:0] b);
    string nm;
    if (is_blank(b)) begin
      if (name_trim == TRIM_IN_NAME) name_trim = TRIM_TRAIL;
    end else begin
      // A second word after blanks can never be a known name.
      if (name_trim == TRIM_TRAIL) cands = '0;
      name_trim = TRIM_IN_NAME;
      for (int k = 0; k < 4; k++) begin
        nm = hdr_name(k);
        if (name_idx >= nm.len() || nm[name_idx] != b) cands[k] = 1'b0;
      end
      if (name_idx < 15) name_idx++;
    end
  endtask

  task automatic value_step(input logic [7:0] b, input int pos);
    longint acc;
    bit     consumed;
    consumed = 1'b0;
    if (!is_blank(b)) begin
      if (!val_nonblank) begin
        val_first = pos;
        val_nonblank = 1'b1;
      end
      val_last = pos;
    end
    if (num_ph == NUM_EXPECT) begin
      if (is_blank(b) || b == CH_VT || b == CH_FF) begin
        consumed = 1'b1;
      end else if (b == CH_PLUS || b == CH_MINUS) begin
        num_neg = (b == CH_MINUS);
        num_ph = NUM_DIGITS;
        consumed = 1'b1;
      end else begin
        num_ph = NUM_DIGITS;
      end
    end
    if (!consumed && num_ph == NUM_DIGITS) begin
      if (b >= CH_ZERO && b <= CH_NINE) begin
        acc = longint'(len_acc) * 10 + longint'(b - CH_ZERO);
        len_acc = (acc > longint'(LEN_MAX)) ? LEN_MAX : acc[LEN_W-1:0];
      end else begin
        num_ph = NUM_DONE;
      end
    end
  endtask

  task automatic close_line();
    kind_t      kd;
    logic [3:0] seen_bit;
    bit         bad;
    int         off;
    int         len;
    string      nm;
    kd = KIND_NONE;
    seen_bit = '0;
    bad = 1'b0;
    if (!val_nonblank) begin
      bad = 1'b1;
    end else begin
      for (int k = 0; k < 4; k++) begin
        nm = hdr_name(k);
        if (cands[k] && name_idx == nm.len()) begin
          kd = hdr_kind(k);
          seen_bit = 4'b0001 << k;
        end
      end
      if (kd != KIND_NONE) begin
        if ((seen & seen_bit) != 0) begin
          bad = 1'b1;
        end else begin
          // The header counts as seen even when its length turns out negative.
          seen = seen | seen_bit;
          if (kd == KIND_LENGTH) begin
            if (num_neg && len_acc != 0) bad = 1'b1;
            else len_stored = len_acc;
          end
        end
      end
    end
    if (bad) begin
      reject_line();
    end else begin
      off = val_first;
      len = val_last - val_first + 1;
      clear_line();
      push_result(ST_OK, kd, off, len);
    end
  endtask

  task automatic predict_beat(input in_item_t it);
    logic [7:0] b;
    int         pos;
    b = it.data_byte;
    if (it.new_request) reset_record();
    pos = int'(line_pos);
    if (int'(line_pos) < MAX_LINE - 1) line_pos = line_pos + 1'b1;
    case (ph)
      PH_LINE_START, PH_NAME: begin
        if (ph == PH_LINE_START && b == CH_CR) begin
          ph = PH_START_CR;
        end else begin
          ph = PH_NAME;
          if (b == CH_COLON) ph = PH_VALUE;
          else if (b == CH_NUL || b == CH_CR || b == CH_LF) reject_line();
          else name_step(b);
        end
      end
      PH_START_CR: begin
        if (b != CH_LF) begin
          reject_line();
        end else begin
          ph = PH_IDLE;
          push_result(ST_END, KIND_NONE, 0, 0);
        end
      end
      PH_VALUE: begin
        if (b == CH_CR) ph = PH_VALUE_CR;
        else if (b == CH_NUL || b == CH_LF) reject_line();
        else value_step(b, pos);
      end
      PH_VALUE_CR: begin
        if (b != CH_LF) reject_line();
        else close_line();
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (line_result_q.size() == 0) begin
      report_mismatch($sformatf("result beat %h with nothing expected", got));
    end else begin
      want = line_result_q.pop_front();
      if (got.status !== want.status)
        report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
      if (got.header_kind !== want.header_kind)
        report_mismatch($sformatf("header_kind %0d, expected %0d",
                                  got.header_kind, want.header_kind));
      if (got.content_length !== want.content_length)
        report_mismatch($sformatf("content_length %0d, expected %0d",
                                  got.content_length, want.content_length));
      if (got.value_offset !== want.value_offset)
        report_mismatch($sformatf("value_offset %0d, expected %0d",
                                  got.value_offset, want.value_offset));
      if (got.value_length !== want.value_length)
        report_mismatch($sformatf("value_length %0d, expected %0d",
                                  got.value_length, want.value_length));
      if (got.seen_mask !== want.seen_mask)
        report_mismatch($sformatf("seen_mask %h, expected %h", got.seen_mask, want.seen_mask));
    end
  endtask

  // Stimulus building.

  task automatic open_request();
    open_pending = 1'b1;
  endtask

  task automatic put_byte(input logic [7:0] b);
    in_item_t it;
    it.data_byte = b;
    it.new_request = open_pending;
    open_pending = 1'b0;
    byte_q.push_back(it);
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
  endtask

  task automatic put_eol();
    put_byte(CH_CR);
    put_byte(CH_LF);
  endtask

  task automatic put_line(input string nm, input string val);
    put_text(nm);
    put_byte(CH_COLON);
    put_text(val);
    put_eol();
  endtask

  function automatic logic [7:0] rand_blank();
    return ($urandom_range(1) == 0) ? CH_SP : CH_TAB;
  endfunction

  function automatic logic [7:0] rand_name_char();
    logic [7:0] c;
    c = 8'($urandom_range(33, 126));
    if (c == CH_COLON) c = 8'h5F;
    return c;
  endfunction

  function automatic logic [7:0] rand_not_lf();
    logic [7:0] c;
    c = 8'($urandom);
    if (c == CH_LF) c = 8'h41;
    return c;
  endfunction

  task automatic put_random_name();
    int    sel;
    int    n;
    string nm;
    sel = $urandom_range(11);
    nm = hdr_name(sel % 4);
    case (sel)
      0, 1, 2, 3, 4, 5: put_text(nm);
      6: begin
        repeat ($urandom_range(1, 2)) put_byte(rand_blank());
        put_text(nm);
        repeat ($urandom_range(2)) put_byte(rand_blank());
      end
      7: begin
        if ($urandom_range(1) == 0) put_text("User Agent");
        else put_text("Content -Length");
      end
      8: begin
        n = $urandom_range(nm.len() - 1);
        for (int i = 0; i < n; i++) put_byte(nm[i]);
      end
      9: begin
        put_text(nm);
        put_byte(rand_name_char());
      end
      10: repeat ($urandom_range(1, 20)) put_byte(rand_name_char());
      default: put_text("host");
    endcase
  endtask

  task automatic put_random_value();
    int         sel;
    int         n;
    logic [7:0] c;
    sel = $urandom_range(7);
    repeat ($urandom_range(2)) put_byte(rand_blank());
    case (sel)
      0, 1, 2, 5: begin
        if (sel == 5) put_byte(($urandom_range(1) == 0) ? CH_VT : CH_FF);
        case ($urandom_range(3))
          0: put_byte(CH_MINUS);
          1: put_byte(CH_PLUS);
          default: ;
        endcase
        // Now and then enough digits to saturate the length.
        n = ($urandom_range(9) == 0) ? $urandom_range(10, 14) : $urandom_range(1, 6);
        repeat (n) put_byte(8'(CH_ZERO + $urandom_range(9)));
        if ($urandom_range(3) == 0) put_byte(rand_name_char());
      end
      3: begin
        repeat ($urandom_range(1, 16)) begin
          if ($urandom_range(3) == 0) put_byte(rand_blank());
          else put_byte(rand_name_char());
        end
      end
      4: repeat ($urandom_range(1, 8)) put_byte(8'($urandom_range(128, 255)));
      6: ;
      default: begin
        repeat ($urandom_range(1, 10)) begin
          c = 8'($urandom_range(1, 255));
          if (c == CH_CR || c == CH_LF) c = 8'h7F;
          put_byte(c);
        end
      end
    endcase
    repeat ($urandom_range(2)) put_byte(rand_blank());
  endtask

  task automatic put_random_line();
    put_random_name();
    put_byte(CH_COLON);
    put_random_value();
    put_eol();
  endtask

  task automatic put_junk();
    repeat ($urandom_range(4)) put_byte(8'($urandom));
  endtask

  task automatic put_good_request();
    open_request();
    repeat ($urandom_range(1, 6)) put_random_line();
    if ($urandom_range(4) != 0) begin
      put_eol();
      put_junk();
    end
  endtask

  task automatic put_broken_request();
    open_request();
    repeat ($urandom_range(2)) put_random_line();
    case ($urandom_range(3))
      0: begin
        put_random_name();
        case ($urandom_range(2))
          0: put_byte(CH_NUL);
          1: put_byte(CH_CR);
          default: put_byte(CH_LF);
        endcase
      end
      1: begin
        put_random_name();
        put_byte(CH_COLON);
        put_random_value();
        put_byte(($urandom_range(1) == 0) ? CH_NUL : CH_LF);
      end
      2: begin
        put_random_name();
        put_byte(CH_COLON);
        put_random_value();
        put_byte(CH_CR);
        put_byte(rand_not_lf());
      end
      default: begin
        put_byte(CH_CR);
        put_byte(rand_not_lf());
      end
    endcase
    put_junk();
  endtask

  task automatic put_noise();
    repeat ($urandom_range(1, 12)) begin
      if ($urandom_range(7) == 0) open_request();
      put_byte(8'($urandom));
    end
  endtask

  task automatic build_stimulus();
    int base;
    int pick;
    open_request();
    put_line("Host", " example.org");
    put_line("User-Agent", "\tcurl ");
    put_line("Content-Type", "text/html");
    put_line("Content-Length", " +42");
    put_line("X-Other", "v");
    put_eol();
    put_text("zz");
    open_request();
    put_line(" Host\t", "a b");
    put_line("Content-Length", "-0");
    put_line("Ho st", "x");
    put_line("host", "x");
    put_line("Content-Length-Extra-Long", "9");
    put_line("User-Agent", " \t ");
    open_request();
    put_line("Content-Length", "99999999999");
    put_line("Content-Length", "1");
    open_request();
    put_line("Content-Length", "-7");
    open_request();
    put_text("Host");
    put_byte(CH_NUL);
    open_request();
    put_byte(CH_CR);
    put_byte(8'hFF);
    open_request();
    put_byte(CH_LF);
    open_request();
    put_text("A");
    put_byte(CH_CR);
    open_request();
    put_text("A: ");
    put_byte(8'hFF);
    put_byte(CH_NUL);
    open_request();
    put_text("A:b");
    put_byte(CH_LF);
    open_request();
    put_text("A:b");
    put_byte(CH_CR);
    put_byte(CH_CR);

    base = byte_q.size();
    while (byte_q.size() - base < RANDOM_BYTES) begin
      pick = $urandom_range(99);
      if (pick < 70) put_good_request();
      else if (pick < 90) put_broken_request();
      else put_noise();
    end
  endtask

  always @(posedge clk) begin
    cyc <= cyc + 1;
  end

  // Sender: a new beat is loaded only once the current one is taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      reset_record();
    end else if (!in_valid || !in_stall) begin
      if (in_valid) predict_beat(in_data);
      if (byte_q.size() != 0 && !take_break()) begin
        in_data <= byte_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls plus two long hold-offs that back the block up.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (cyc == HOLD_AT_A || cyc == HOLD_AT_B) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_LEN;
    end else begin
      out_stall <= take_break();
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) check_result(out_data);
  end

  initial begin
    build_stimulus();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    while (byte_q.size() != 0 || in_valid) @(posedge clk);
    while (line_result_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

### http_header_line_parser_top.f
src/hhlp_pkg.sv
src/hhlp_front.sv
src/hhlp_queue.sv
src/hhlp_back.sv
src/http_header_line_parser_top.sv
bench/http_header_line_parser_top_tb.sv
